// ===== hw/rtl/dssm_pkg.sv =====
`timescale 1ns / 1ps

package dssm_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_SHOW = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request into the datapath
    logic exec;     // decide the request, update counts, present the first read
    logic load;     // move the store read data into the result register
    logic advance;  // step the display walk to the next element
  } dssm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             immediate;  // result known without reading the store
    logic             last;       // result register holds the final result
    logic [CNT_W:0]   total;      // words held by both stacks
  } dssm_sts_t;

endpackage

// ===== hw/rtl/dual_stack_shared_memory_unit.sv =====
`timescale 1ns / 1ps

// Two stacks in one store of DEPTH 32-bit words: stack A grows up from entry 0
// and stack B grows down from the top entry. Each request names a stack and a
// push, pop, peek or display, and is answered by one result, or by one result
// per element for a display of a non-empty stack, the final one flagged by
// out_last. A push returns status overflow when the store is full, pop, peek and
// display of an empty stack return underflow, both with zero data. One request
// is handled at a time: a push or any request answered without a store read
// goes from acceptance through the execute and output states, a pop or peek
// through execute, read and output, and each further display element through
// fetch, read and output; the output state holds while out_stall is high.
// The store has a registered read port and needs no clearing pass after reset.
module dual_stack_shared_memory_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_command,
  input  logic                               in_stack_select,
  input  logic signed [dssm_pkg::DATA_W-1:0] in_push_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dssm_pkg::DATA_W-1:0] out_data_value,
  output logic [1:0]                         out_status,
  output logic                               out_last
);
  import dssm_pkg::*;

  dssm_cmd_t cmd;
  dssm_sts_t sts;

  dssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dssm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_stack_select (in_stack_select),
    .in_push_value   (in_push_value),
    .out_data_value  (out_data_value),
    .out_status      (out_status),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.total <= (CNT_W + 1)'(DEPTH))
    else $error("stacks hold more words than the store");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in progress");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid)
    else $error("result follows the final result of a request");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last && (out_data_value == '0))
    else $error("failure result not single or carries data");

endmodule

// ===== hw/rtl/dssm_ram.sv =====
`timescale 1ns / 1ps

module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/dssm_ctrl.sv =====
`timescale 1ns / 1ps

module dssm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output dssm_pkg::dssm_cmd_t cmd,
  input  dssm_pkg::dssm_sts_t sts
);
  import dssm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = sts.immediate ? S_OUT : S_READ;
      end
      S_FETCH: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = sts.last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.load    = (state_r == S_READ);
  assign cmd.advance = (state_r == S_OUT) && !out_stall && !sts.last;

endmodule

// ===== hw/rtl/dssm_dp.sv =====
`timescale 1ns / 1ps

module dssm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [1:0]                         in_command,
  input  logic                               in_stack_select,
  input  logic signed [dssm_pkg::DATA_W-1:0] in_push_value,
  output logic signed [dssm_pkg::DATA_W-1:0] out_data_value,
  output logic [1:0]                         out_status,
  output logic                               out_last,
  input  dssm_pkg::dssm_cmd_t                cmd,
  output dssm_pkg::dssm_sts_t                sts
);
  import dssm_pkg::*;

  logic [CNT_W-1:0]  count_a_r, count_a_nxt;
  logic [CNT_W-1:0]  count_b_r, count_b_nxt;
  logic [1:0]        cmd_r;
  logic              sel_r;
  logic [DATA_W-1:0] val_r;
  logic [ADDR_W-1:0] walk_r;
  logic [DATA_W-1:0] data_r;
  logic [1:0]        status_r;
  logic              last_r;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W:0]    total;
  logic              full;
  logic              empty;
  logic              immediate;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  wr_idx;
  logic              we;
  logic [DATA_W-1:0] rdata;
  logic              walk_done;

  assign cnt       = sel_r ? count_b_r : count_a_r;
  assign total     = {1'b0, count_a_r} + {1'b0, count_b_r};
  assign full      = (total >= (CNT_W + 1)'(DEPTH));
  assign empty     = (cnt == '0);
  assign immediate = (cmd_r == CMD_PUSH) || empty;
  assign walk_done = ({1'b0, walk_r} + CNT_W'(1)) == cnt;

  // Stack A tops out at count_a-1 and walks down; stack B tops out at
  // DEPTH-count_b and walks up.
  assign rd_idx = sel_r ? (CNT_W'(DEPTH) - count_b_r + {1'b0, walk_r})
                        : (count_a_r - CNT_W'(1) - {1'b0, walk_r});
  assign wr_idx = sel_r ? (CNT_W'(DEPTH) - CNT_W'(1) - count_b_r) : count_a_r;
  assign we     = cmd.exec && (cmd_r == CMD_PUSH) && !full;

  dssm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (wr_idx[ADDR_W-1:0]),
    .wdata (val_r),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    count_a_nxt = count_a_r;
    count_b_nxt = count_b_r;
    if (cmd.exec) begin
      if (we) begin
        if (sel_r) begin
          count_b_nxt = count_b_r + CNT_W'(1);
        end else begin
          count_a_nxt = count_a_r + CNT_W'(1);
        end
      end else if ((cmd_r == CMD_POP) && !empty) begin
        if (sel_r) begin
          count_b_nxt = count_b_r - CNT_W'(1);
        end else begin
          count_a_nxt = count_a_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
    end else begin
      count_a_r <= count_a_nxt;
      count_b_r <= count_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_command;
      sel_r  <= in_stack_select;
      val_r  <= in_push_value;
      walk_r <= '0;
    end else if (cmd.advance) begin
      walk_r <= walk_r + ADDR_W'(1);
    end

    if (cmd.exec && immediate) begin
      data_r   <= '0;
      status_r <= (cmd_r != CMD_PUSH) ? ST_UNDER : (full ? ST_OVER : ST_OK);
      last_r   <= 1'b1;
    end else if (cmd.load) begin
      data_r   <= rdata;
      status_r <= ST_OK;
      // A pop has already lowered its count, so only a display checks the walk.
      last_r   <= (cmd_r != CMD_SHOW) || walk_done;
    end
  end

  assign out_data_value = data_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

  assign sts.immediate = immediate;
  assign sts.last      = last_r;
  assign sts.total     = total;

endmodule
